// ===== design/hsfe_pkg.sv =====
// Package: node sign table, control struct and constants for the hex20 shape unit.
`timescale 1ns / 1ps
package hsfe_pkg;

    localparam int COORD_BITS = 20;
    localparam int NODE_COUNT = 20;
    localparam int VALUE_BITS = 32;

    typedef logic signed [1:0] t_sgn;
    typedef t_sgn [2:0] t_sgn3;

    typedef enum logic [1:0] {
        OP_VALUE = 2'd0,
        OP_DXI   = 2'd1,
        OP_DETA  = 2'd2,
        OP_DZETA = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SH_ONE   = 2'd1,
        SH_TWO   = 2'd2,
        SH_THREE = 2'd3
    } t_sh;

    typedef struct packed {
        t_sh  sh;
        logic neg;
        logic zero;
    } t_ctrl;

    localparam t_sgn SP = 2'sd1;
    localparam t_sgn SN = -2'sd1;
    localparam t_sgn SZ = 2'sd0;

    // Index 0 is xi, 1 eta, 2 zeta.
    function automatic t_sgn3 node_signs(input logic [4:0] node);
        t_sgn3 s;
        unique case (node)
            5'd0:    s = '{SN, SN, SN};
            5'd1:    s = '{SN, SN, SP};
            5'd2:    s = '{SN, SP, SP};
            5'd3:    s = '{SN, SP, SN};
            5'd4:    s = '{SP, SN, SN};
            5'd5:    s = '{SP, SN, SP};
            5'd6:    s = '{SP, SP, SP};
            5'd7:    s = '{SP, SP, SN};
            5'd8:    s = '{SN, SN, SZ};
            5'd9:    s = '{SN, SZ, SN};
            5'd10:   s = '{SZ, SN, SN};
            5'd11:   s = '{SN, SZ, SP};
            5'd12:   s = '{SZ, SN, SP};
            5'd13:   s = '{SN, SP, SZ};
            5'd14:   s = '{SZ, SP, SP};
            5'd15:   s = '{SZ, SP, SN};
            5'd16:   s = '{SP, SN, SZ};
            5'd17:   s = '{SP, SZ, SN};
            5'd18:   s = '{SP, SZ, SP};
            5'd19:   s = '{SP, SP, SZ};
            default: s = '{SZ, SZ, SZ};
        endcase
        return s;
    endfunction

endpackage

// ===== design/hex20_shape_function_eval_top.sv =====
// Top level: pipelined 20-node serendipity hexahedron shape function evaluator.
//
//  channel | direction | handshake            | payload
//  input   | in        | i_valid / o_ready    | i_op, i_node, i_coord_xi/eta/zeta
//  result  | out       | o_valid / i_ready    | o_value, o_saturated
//
// Five register stages: decode, three fixed-point multiplies, round and clip.
// One item per cycle while the output is not stalled.
// The whole pipeline advances when the output stage is empty or taken; a stall
// freezes every stage. Synchronous active-low reset clears all valid bits.
`timescale 1ns / 1ps
module hex20_shape_function_eval_top
    import hsfe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_op,
    input  logic [4:0]                   i_node,
    input  logic signed [COORD_BITS-1:0] i_coord_xi,
    input  logic signed [COORD_BITS-1:0] i_coord_eta,
    input  logic signed [COORD_BITS-1:0] i_coord_zeta,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic                         o_saturated
);

    localparam int F    = FRAC_BITS;
    localparam int SQW  = 2 * (COORD_BITS - 1) - F;
    localparam int BW   = (COORD_BITS > F + 1) ? COORD_BITS : F + 1;
    localparam int OW   = ((SQW > BW) ? SQW : BW) + 3;
    localparam int P1W  = 2 * OW + 2;
    localparam int R1   = P1W - F + 1;
    localparam int X2W  = R1 + 1;
    localparam int P2W  = X2W + OW + 1;
    localparam int R2   = P2W - F + 1;
    localparam int P3W  = R2 + OW + 1;
    localparam int R3   = P3W - F + 1;

    typedef logic signed [OW:0] t_opnd;

    localparam t_opnd ONE = t_opnd'(1) <<< F;
    localparam logic [P1W-1:0] HALF1 = P1W'(1) << (F - 1);
    localparam logic [P2W-1:0] HALF2 = P2W'(1) << (F - 1);
    localparam logic [P3W-1:0] HALF3 = P3W'(1) << (F - 1);
    localparam logic [R3-1:0] POS_MAX = R3'(32'h7fffffff);
    localparam logic [R3-1:0] NEG_MAX = R3'(33'h080000000);

    logic en;
    logic r_v0, r_v1, r_v2, r_v3, r_v4;
    t_ctrl r_c0, r_c1, r_c2, r_c3;
    logic r_q0;
    t_opnd r_a0, r_b0, r_cc0, r_d0, r_cc1, r_d1, r_d2;
    logic signed [R1-1:0] r_m1;
    logic signed [R2-1:0] r_m2;
    logic signed [R3-1:0] r_m3;
    logic r_q1;
    logic signed [VALUE_BITS-1:0] r_value;
    logic r_sat;

    assign en      = !r_v4 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v4;
    assign o_value = r_value;
    assign o_saturated = r_sat;

    // Decode
    t_sgn3 sg;
    t_opnd cx [3];
    t_opnd fx [3];
    t_opnd sc [3];
    logic [1:0] zax, ax, ux, vx, ua, va;
    t_opnd lin_v, lin_d;
    t_opnd n_a, n_b, n_cc, n_d;
    logic n_q;
    t_ctrl n_c;

    always_comb begin
        sg = node_signs(i_node);
        cx[0] = t_opnd'(i_coord_xi);
        cx[1] = t_opnd'(i_coord_eta);
        cx[2] = t_opnd'(i_coord_zeta);
        for (int k = 0; k < 3; k++) begin
            if (sg[k] == SP) begin
                fx[k] = ONE + cx[k];
                sc[k] = cx[k];
            end else if (sg[k] == SN) begin
                fx[k] = ONE - cx[k];
                sc[k] = -cx[k];
            end else begin
                fx[k] = ONE;
                sc[k] = '0;
            end
        end
        if (sg[0] == SZ) begin
            zax = 2'd0;
        end else if (sg[1] == SZ) begin
            zax = 2'd1;
        end else if (sg[2] == SZ) begin
            zax = 2'd2;
        end else begin
            zax = 2'd3;
        end
        ax = i_op - 2'd1;
        ua = (ax == 2'd0) ? 2'd1 : 2'd0;
        va = (ax == 2'd2) ? 2'd1 : 2'd2;
        ux = (zax == 2'd0) ? 2'd1 : 2'd0;
        vx = (zax == 2'd2) ? 2'd1 : 2'd2;
        lin_v = sc[0] + sc[1] + sc[2] - (ONE <<< 1);
        lin_d = (sc[ax] <<< 1) + sc[ua] + sc[va] - ONE;

        n_c.zero = (i_node >= 5'(NODE_COUNT));
        n_c.neg  = 1'b0;
        n_c.sh   = SH_THREE;
        n_q  = 1'b0;
        n_a  = ONE;
        n_b  = ONE;
        n_cc = ONE;
        n_d  = ONE;
        if (zax == 2'd3) begin
            if (i_op == OP_VALUE) begin
                n_a  = fx[0];
                n_b  = fx[1];
                n_cc = fx[2];
                n_d  = lin_v;
            end else begin
                n_a  = fx[ua];
                n_b  = fx[va];
                n_cc = lin_d;
                n_c.neg = (sg[ax] == SN);
            end
        end else if (i_op == OP_VALUE) begin
            n_a  = cx[zax];
            n_b  = cx[zax];
            n_q  = 1'b1;
            n_cc = fx[ux];
            n_d  = fx[vx];
            n_c.sh = SH_TWO;
        end else if (ax == zax) begin
            n_a  = cx[zax];
            n_b  = fx[ux];
            n_cc = fx[vx];
            n_c.sh  = SH_ONE;
            n_c.neg = 1'b1;
        end else begin
            n_a  = cx[zax];
            n_b  = cx[zax];
            n_q  = 1'b1;
            n_c.sh = SH_TWO;
            if (ax == ux) begin
                n_cc = fx[vx];
                n_c.neg = (sg[ux] == SN);
            end else begin
                n_cc = fx[ux];
                n_c.neg = (sg[vx] == SN);
            end
        end
    end

    // Multiply 1
    logic [OW:0] am, bm;
    logic [P1W-1:0] p1, t1;
    logic signed [R1-1:0] n_m1;
    always_comb begin
        am = r_a0[OW] ? -r_a0 : r_a0;
        bm = r_b0[OW] ? -r_b0 : r_b0;
        p1 = P1W'(am) * P1W'(bm);
        t1 = (p1 + HALF1) >> F;
        n_m1 = (r_a0[OW] ^ r_b0[OW]) ? -R1'(t1) : R1'(t1);
    end

    // Multiply 2
    logic signed [X2W-1:0] x2;
    logic [X2W-1:0] xm2;
    logic [OW:0] cm2;
    logic [P2W-1:0] p2, t2;
    logic signed [R2-1:0] n_m2;
    always_comb begin
        x2 = r_q1 ? (X2W'(ONE) - X2W'(r_m1)) : X2W'(r_m1);
        xm2 = x2[X2W-1] ? -x2 : x2;
        cm2 = r_cc1[OW] ? -r_cc1 : r_cc1;
        p2 = P2W'(xm2) * P2W'(cm2);
        t2 = (p2 + HALF2) >> F;
        n_m2 = (x2[X2W-1] ^ r_cc1[OW]) ? -R2'(t2) : R2'(t2);
    end

    // Multiply 3
    logic [R2-1:0] xm3;
    logic [OW:0] dm3;
    logic [P3W-1:0] p3, t3;
    logic signed [R3-1:0] n_m3;
    always_comb begin
        xm3 = r_m2[R2-1] ? -r_m2 : r_m2;
        dm3 = r_d2[OW] ? -r_d2 : r_d2;
        p3 = P3W'(xm3) * P3W'(dm3);
        t3 = (p3 + HALF3) >> F;
        n_m3 = (r_m2[R2-1] ^ r_d2[OW]) ? -R3'(t3) : R3'(t3);
    end

    // Round, sign, clip
    logic [R3-1:0] mm, rm;
    logic neg4;
    logic signed [VALUE_BITS-1:0] n_value;
    logic n_sat;
    always_comb begin
        mm = r_m3[R3-1] ? -r_m3 : r_m3;
        case (r_c3.sh)
            SH_ONE:  rm = (mm + R3'(1)) >> 1;
            SH_TWO:  rm = (mm + R3'(2)) >> 2;
            default: rm = (mm + R3'(4)) >> 3;
        endcase
        neg4 = r_m3[R3-1] ^ r_c3.neg;
        n_sat = 1'b0;
        if (r_c3.zero) begin
            n_value = '0;
        end else if (!neg4 && rm > POS_MAX) begin
            n_value = 32'sh7fffffff;
            n_sat = 1'b1;
        end else if (neg4 && rm > NEG_MAX) begin
            n_value = 32'sh80000000;
            n_sat = 1'b1;
        end else if (neg4) begin
            n_value = -VALUE_BITS'(rm);
        end else begin
            n_value = VALUE_BITS'(rm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a0  <= n_a;
            r_b0  <= n_b;
            r_cc0 <= n_cc;
            r_d0  <= n_d;
            r_q0  <= n_q;
            r_c0  <= n_c;
            r_m1  <= n_m1;
            r_cc1 <= r_cc0;
            r_d1  <= r_d0;
            r_q1  <= r_q0;
            r_c1  <= r_c0;
            r_m2  <= n_m2;
            r_d2  <= r_d1;
            r_c2  <= r_c1;
            r_m3  <= n_m3;
            r_c3  <= r_c2;
            r_value <= n_value;
            r_sat   <= n_sat;
        end
    end

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (o_value == 32'sh7fffffff || o_value == 32'sh80000000))
        else $error("saturated flag without clipped value");

    a_zero_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_c3.zero && en |=> o_valid && o_value == '0 && !o_saturated)
        else $error("out-of-range node gave nonzero result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r_v3)
        else $error("pipeline not empty after reset");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && en |=> r_v3)
        else $error("item lost between stages");

endmodule
